/* design/edf_pkg.sv */
`default_nettype none
package edf_pkg;

   localparam int DL_W     = 15;
   localparam int UTIL_W   = 16;
   localparam int UTOT_W   = 17;
   localparam int STATUS_W = 3;
   localparam int OUT_IDX_W = 4;

   localparam logic [DL_W-1:0]   DL_MAX  = 15'h7FFF;
   localparam logic [UTOT_W:0]   ONE_Q16 = 18'd65536;
   localparam logic [UTIL_W-1:0] UTIL_SAT = 16'hFFFF;

   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_END      = 2'd1;
   localparam logic [1:0] OP_ACTIVATE = 2'd2;
   localparam logic [1:0] OP_CREATE   = 2'd3;

   localparam logic [2:0] PH_FREE   = 3'd0;
   localparam logic [2:0] PH_SLEEP  = 3'd1;
   localparam logic [2:0] PH_READY  = 3'd2;
   localparam logic [2:0] PH_IDLE   = 3'd3;
   localparam logic [2:0] PH_ZOMBIE = 3'd4;
   localparam logic [2:0] PH_EXEC   = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_GUAR   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EXPIRED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERRUN    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NONE_READY = 3'd5;

   function automatic logic [DL_W-1:0] sat_add(input logic [DL_W-1:0] a,
                                               input logic [DL_W-1:0] b);
      logic [DL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DL_W] ? DL_MAX : s[DL_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* design/edf_if.sv */
`default_nettype none
interface edf_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               op;
   logic [3:0]               task_slot;
   logic [edf_pkg::DL_W-1:0] period_ticks;
   logic [edf_pkg::DL_W-1:0] wcet_ticks;
   logic                     hard_task;
   logic                     main_type;

   modport source (output valid, op, task_slot, period_ticks, wcet_ticks, hard_task,
                   main_type, input ready);
   modport sink   (input valid, op, task_slot, period_ticks, wcet_ticks, hard_task,
                   main_type, output ready);
endinterface

interface edf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [edf_pkg::STATUS_W-1:0]  status;
   logic [edf_pkg::OUT_IDX_W-1:0] running_task;
   logic [edf_pkg::OUT_IDX_W-1:0] created_task;
   logic                          switched;

   modport source (output valid, status, running_task, created_task, switched,
                   input ready);
   modport sink   (input valid, status, running_task, created_task, switched,
                   output ready);
endinterface
`default_nettype wire

/* design/edf_task_scheduler_core.sv */
`default_nettype none
// Channel   Dir  Beat
// req_chan  in   op, task_slot, period_ticks, wcet_ticks, hard_task, main_type
// rsp_chan  out  status, running_task, created_task, switched
// csr_*     in   lifetime_ticks write (one register)
//
// One item at a time. Task records live in a one-read, one-write memory with
// registered read; list walks visit one entry per cycle, and a hard create runs
// a bit-serial divide.
// After reset a clearing pass over all TASK_COUNT entries fills the table; req is held off.
// A new beat is taken while a finished response still waits in the output register.
module edf_task_scheduler_core #(
   parameter int TASK_COUNT = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   edf_req_if.sink                       req_chan,
   edf_rsp_if.source                     rsp_chan,
   input  wire logic                     csr_write_enable,
   input  wire logic [edf_pkg::DL_W-1:0] csr_write_data
);

   localparam int IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
   localparam int LW = IW + 1;
   localparam logic [LW-1:0] NIL = {LW{1'b1}};
   localparam logic [LW-1:0] LINK_N = LW'(TASK_COUNT);
   localparam logic [IW-1:0] LAST_IDX = IW'(TASK_COUNT - 1);

   localparam logic [4:0] S_CLEAR    = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_TICK     = 5'd2;
   localparam logic [4:0] S_IDLE_CHK = 5'd3;
   localparam logic [4:0] S_IDLE_RD  = 5'd4;
   localparam logic [4:0] S_SCHED    = 5'd5;
   localparam logic [4:0] S_SCHED_RD = 5'd6;
   localparam logic [4:0] S_END      = 5'd7;
   localparam logic [4:0] S_ACT      = 5'd8;
   localparam logic [4:0] S_ACT_RD   = 5'd9;
   localparam logic [4:0] S_CRE      = 5'd10;
   localparam logic [4:0] S_DIV      = 5'd11;
   localparam logic [4:0] S_CRE_CHK  = 5'd12;
   localparam logic [4:0] S_CRE_WR   = 5'd13;
   localparam logic [4:0] S_INS      = 5'd14;
   localparam logic [4:0] S_INS_CMP  = 5'd15;
   localparam logic [4:0] S_INS_LINK = 5'd16;
   localparam logic [4:0] S_INS_SELF = 5'd17;
   localparam logic [4:0] S_DISP     = 5'd18;
   localparam logic [4:0] S_DISP_RD  = 5'd19;
   localparam logic [4:0] S_RESP     = 5'd20;

   localparam logic LIST_READY = 1'b0;
   localparam logic LIST_IDLE  = 1'b1;

   typedef struct packed {
      logic [edf_pkg::DL_W-1:0] dl;
      logic [edf_pkg::DL_W-1:0] per;
      logic                     hard;
      logic [LW-1:0]            nxt;
      logic [2:0]               phase;
   } task_rec_type;

   task_rec_type mem [TASK_COUNT];
   task_rec_type rdata_ff;
   logic         mem_we;
   logic [IW-1:0] mem_wa, mem_ra;
   task_rec_type mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rdata_ff <= mem[mem_ra];
   end

   logic [4:0] state_ff, state_in, ret_ff, ret_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [3:0] tix_ff, tix_in;
   logic [edf_pkg::DL_W-1:0] per_ff, per_in, wcet_ff, wcet_in;
   logic hard_ff, hard_in, main_ff, main_in;
   logic [edf_pkg::DL_W-1:0] clk_ff, clk_in, life_ff, life_in;
   logic [LW-1:0] rhead_ff, rhead_in, ihead_ff, ihead_in, free_ff, free_in;
   logic [LW-1:0] nxt_ff, nxt_in;
   task_rec_type run_ff, run_in, cur_ff, cur_in, prv_ff, prv_in;
   logic [IW-1:0] run_idx_ff, run_idx_in, cur_idx_ff, cur_idx_in, prv_idx_ff, prv_idx_in;
   logic run_vld_ff, run_vld_in, prv_vld_ff, prv_vld_in;
   logic old_vld_ff, old_vld_in;
   logic [IW-1:0] old_idx_ff, old_idx_in;
   logic sel_ff, sel_in, woke_ff, woke_in, rchg_ff, rchg_in;
   logic [edf_pkg::UTOT_W-1:0] utot_ff, utot_in;
   logic [edf_pkg::UTIL_W-1:0] util_ff, util_in;
   logic [edf_pkg::DL_W-1:0] rem_ff, rem_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [2:0] fault_ff, fault_in, st_ff, st_in;
   logic [3:0] created_ff, created_in;
   logic rsp_vld_ff, rsp_vld_in;
   logic [2:0] rsp_st_ff, rsp_st_in;
   logic [3:0] rsp_run_ff, rsp_run_in, rsp_cre_ff, rsp_cre_in;
   logic rsp_sw_ff, rsp_sw_in;

   logic req_acc;
   logic [edf_pkg::DL_W-1:0] clk_next;
   logic [edf_pkg::DL_W:0] rem2, rem_sub;
   logic [edf_pkg::UTOT_W:0] usum;
   logic [LW:0] free_inc;
   logic [LW-1:0] head_sel, rd_nxt;
   task_rec_type clr_rec;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_acc = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.status = rsp_st_ff;
   assign rsp_chan.running_task = rsp_run_ff;
   assign rsp_chan.created_task = rsp_cre_ff;
   assign rsp_chan.switched = rsp_sw_ff;

   assign clk_next = clk_ff + 15'd1;
   assign rem2 = {rem_ff, 1'b0};
   assign rem_sub = rem2 - {1'b0, per_ff};
   assign usum = {1'b0, utot_ff} + {2'b00, util_ff};
   assign free_inc = {1'b0, free_ff} + {{LW{1'b0}}, 1'b1};
   assign head_sel = (sel_ff == LIST_IDLE) ? ihead_ff : rhead_ff;
   assign rd_nxt = (rdata_ff.nxt >= LINK_N) ? NIL : rdata_ff.nxt;

   always_comb begin
      clr_rec = '0;
      clr_rec.phase = edf_pkg::PH_FREE;
      clr_rec.nxt = ({1'b0, clr_ff} + {{IW{1'b0}}, 1'b1} >= LINK_N) ? NIL
                    : ({1'b0, clr_ff} + {{IW{1'b0}}, 1'b1});
      if (clr_ff == '0) begin
         clr_rec.dl = edf_pkg::DL_MAX;
         clr_rec.phase = edf_pkg::PH_EXEC;
      end
   end

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; clr_in = clr_ff;
      tix_in = tix_ff; per_in = per_ff; wcet_in = wcet_ff;
      hard_in = hard_ff; main_in = main_ff;
      clk_in = clk_ff; life_in = life_ff;
      rhead_in = rhead_ff; ihead_in = ihead_ff; free_in = free_ff; nxt_in = nxt_ff;
      run_in = run_ff; cur_in = cur_ff; prv_in = prv_ff;
      run_idx_in = run_idx_ff; cur_idx_in = cur_idx_ff; prv_idx_in = prv_idx_ff;
      run_vld_in = run_vld_ff; prv_vld_in = prv_vld_ff;
      old_vld_in = old_vld_ff; old_idx_in = old_idx_ff;
      sel_in = sel_ff; woke_in = woke_ff; rchg_in = rchg_ff;
      utot_in = utot_ff; util_in = util_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      fault_in = fault_ff; st_in = st_ff; created_in = created_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_chan.ready;
      rsp_st_in = rsp_st_ff; rsp_run_in = rsp_run_ff; rsp_cre_in = rsp_cre_ff;
      rsp_sw_in = rsp_sw_ff;
      mem_we = 1'b0; mem_wa = '0; mem_wd = cur_ff; mem_ra = '0;

      if (csr_write_enable) life_in = csr_write_data;

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = clr_rec;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_acc) begin
               tix_in = req_chan.task_slot;
               per_in = req_chan.period_ticks; wcet_in = req_chan.wcet_ticks;
               hard_in = req_chan.hard_task; main_in = req_chan.main_type;
               old_vld_in = run_vld_ff; old_idx_in = run_idx_ff;
               st_in = edf_pkg::ST_OK; created_in = '0; woke_in = 1'b0;
               if (fault_ff != edf_pkg::ST_OK) state_in = S_RESP;
               else begin
                  case (req_chan.op)
                     edf_pkg::OP_TICK:     state_in = S_TICK;
                     edf_pkg::OP_END:      state_in = S_END;
                     edf_pkg::OP_ACTIVATE: state_in = S_ACT;
                     default:              state_in = S_CRE;
                  endcase
               end
            end
         end
         S_TICK: begin
            clk_in = clk_next;
            if (clk_next >= life_ff) begin
               fault_in = edf_pkg::ST_EXPIRED;
               state_in = S_RESP;
            end else if (run_vld_ff && run_ff.hard && clk_next > run_ff.dl) begin
               fault_in = edf_pkg::ST_OVERRUN;
               state_in = S_RESP;
            end else state_in = S_IDLE_CHK;
         end
         S_IDLE_CHK: begin
            if (ihead_ff >= LINK_N) state_in = S_SCHED;
            else begin
               mem_ra = ihead_ff[IW-1:0];
               state_in = S_IDLE_RD;
            end
         end
         S_IDLE_RD: begin
            if (rdata_ff.dl <= clk_ff) begin
               ihead_in = rd_nxt;
               cur_in = rdata_ff;
               cur_in.dl = edf_pkg::sat_add(rdata_ff.dl, rdata_ff.per);
               cur_idx_in = ihead_ff[IW-1:0];
               woke_in = 1'b1;
               sel_in = LIST_READY;
               ret_in = S_IDLE_CHK;
               state_in = S_INS;
            end else state_in = S_SCHED;
         end
         S_SCHED: begin
            if (!(woke_ff || rchg_ff)) state_in = S_RESP;
            else begin
               rchg_in = 1'b0;
               if (rhead_ff >= LINK_N) state_in = S_RESP;
               else if (!run_vld_ff) state_in = S_DISP;
               else begin
                  mem_ra = rhead_ff[IW-1:0];
                  state_in = S_SCHED_RD;
               end
            end
         end
         S_SCHED_RD: begin
            if (rdata_ff.dl < run_ff.dl) begin
               cur_in = run_ff;
               cur_idx_in = run_idx_ff;
               sel_in = LIST_READY;
               ret_in = S_DISP;
               state_in = S_INS;
            end else state_in = S_RESP;
         end
         S_END: begin
            if (run_vld_ff) begin
               cur_in = run_ff;
               cur_idx_in = run_idx_ff;
               ret_in = S_DISP;
               state_in = S_INS;
               if (clk_ff < run_ff.dl) sel_in = LIST_IDLE;
               else begin
                  cur_in.dl = edf_pkg::sat_add(run_ff.dl, run_ff.per);
                  sel_in = LIST_READY;
               end
            end else state_in = S_DISP;
         end
         S_ACT: begin
            if (int'(tix_ff) < TASK_COUNT) begin
               mem_ra = IW'(tix_ff);
               state_in = S_ACT_RD;
            end else state_in = S_RESP;
         end
         S_ACT_RD: begin
            if (rdata_ff.phase == edf_pkg::PH_SLEEP) begin
               rchg_in = 1'b1;
               cur_in = rdata_ff;
               if (rdata_ff.hard) cur_in.dl = edf_pkg::sat_add(clk_ff, rdata_ff.per);
               cur_idx_in = IW'(tix_ff);
               sel_in = LIST_READY;
               ret_in = S_RESP;
               state_in = S_INS;
            end else state_in = S_RESP;
         end
         S_CRE: begin
            if (free_ff >= LINK_N) begin
               st_in = edf_pkg::ST_NO_FREE;
               state_in = S_RESP;
            end else if (!hard_ff) state_in = S_CRE_WR;
            else if (wcet_ff > per_ff) begin
               st_in = edf_pkg::ST_NOT_GUAR;
               state_in = S_RESP;
            end else if (wcet_ff == per_ff) begin
               util_in = (per_ff == '0) ? '0 : edf_pkg::UTIL_SAT;
               state_in = S_CRE_CHK;
            end else begin
               rem_in = wcet_ff;
               util_in = '0;
               cnt_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (rem2 >= {1'b0, per_ff}) begin
               rem_in = rem_sub[edf_pkg::DL_W-1:0];
               util_in = {util_ff[edf_pkg::UTIL_W-2:0], 1'b1};
            end else begin
               rem_in = rem2[edf_pkg::DL_W-1:0];
               util_in = {util_ff[edf_pkg::UTIL_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) state_in = S_CRE_CHK;
         end
         S_CRE_CHK: begin
            if (usum > edf_pkg::ONE_Q16) begin
               st_in = edf_pkg::ST_NOT_GUAR;
               state_in = S_RESP;
            end else begin
               utot_in = usum[edf_pkg::UTOT_W-1:0];
               state_in = S_CRE_WR;
            end
         end
         S_CRE_WR: begin
            mem_we = 1'b1;
            mem_wa = free_ff[IW-1:0];
            mem_wd.dl = main_ff ? edf_pkg::DL_MAX : per_ff;
            mem_wd.per = per_ff;
            mem_wd.hard = hard_ff;
            mem_wd.nxt = NIL;
            mem_wd.phase = edf_pkg::PH_SLEEP;
            created_in = 4'(free_ff[IW-1:0]);
            free_in = (free_inc >= {1'b0, LINK_N}) ? NIL : free_inc[LW-1:0];
            state_in = S_RESP;
         end
         S_INS: begin
            prv_vld_in = 1'b0;
            nxt_in = head_sel;
            if (head_sel >= LINK_N) begin
               nxt_in = NIL;
               state_in = S_INS_LINK;
            end else begin
               mem_ra = head_sel[IW-1:0];
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            // equal deadlines go after the existing entry
            if (cur_ff.dl >= rdata_ff.dl) begin
               prv_vld_in = 1'b1;
               prv_idx_in = nxt_ff[IW-1:0];
               prv_in = rdata_ff;
               nxt_in = rd_nxt;
               if (rd_nxt == NIL) state_in = S_INS_LINK;
               else mem_ra = rd_nxt[IW-1:0];
            end else state_in = S_INS_LINK;
         end
         S_INS_LINK: begin
            if (prv_vld_ff) begin
               mem_we = 1'b1;
               mem_wa = prv_idx_ff;
               mem_wd = prv_ff;
               mem_wd.nxt = {1'b0, cur_idx_ff};
            end else if (sel_ff == LIST_IDLE) ihead_in = {1'b0, cur_idx_ff};
            else rhead_in = {1'b0, cur_idx_ff};
            state_in = S_INS_SELF;
         end
         S_INS_SELF: begin
            mem_we = 1'b1;
            mem_wa = cur_idx_ff;
            mem_wd = cur_ff;
            mem_wd.nxt = nxt_ff;
            mem_wd.phase = (sel_ff == LIST_IDLE) ? edf_pkg::PH_IDLE : edf_pkg::PH_READY;
            state_in = ret_ff;
         end
         S_DISP: begin
            if (rhead_ff >= LINK_N) begin
               run_vld_in = 1'b0;
               state_in = S_RESP;
            end else begin
               mem_ra = rhead_ff[IW-1:0];
               state_in = S_DISP_RD;
            end
         end
         S_DISP_RD: begin
            rhead_in = rd_nxt;
            run_in = rdata_ff;
            run_idx_in = rhead_ff[IW-1:0];
            run_vld_in = 1'b1;
            mem_we = 1'b1;
            mem_wa = rhead_ff[IW-1:0];
            mem_wd = rdata_ff;
            mem_wd.phase = edf_pkg::PH_EXEC;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in = 1'b1;
               if (fault_ff != edf_pkg::ST_OK) rsp_st_in = fault_ff;
               else if (st_ff != edf_pkg::ST_OK) rsp_st_in = st_ff;
               else if (!run_vld_ff) rsp_st_in = edf_pkg::ST_NONE_READY;
               else rsp_st_in = edf_pkg::ST_OK;
               rsp_run_in = run_vld_ff ? 4'(run_idx_ff) : 4'd0;
               rsp_cre_in = created_ff;
               rsp_sw_in = (run_vld_ff != old_vld_ff) ||
                           (run_vld_ff && (run_idx_ff != old_idx_ff));
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         clk_ff <= '0;
         life_ff <= edf_pkg::DL_MAX;
         rhead_ff <= NIL;
         ihead_ff <= NIL;
         free_ff <= (TASK_COUNT > 1) ? LW'(1) : NIL;
         run_ff <= '{dl: edf_pkg::DL_MAX, per: '0, hard: 1'b0, nxt: NIL,
                     phase: edf_pkg::PH_EXEC};
         run_idx_ff <= '0;
         run_vld_ff <= 1'b1;
         rchg_ff <= 1'b0;
         utot_ff <= '0;
         fault_ff <= edf_pkg::ST_OK;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         clk_ff <= clk_in;
         life_ff <= life_in;
         rhead_ff <= rhead_in;
         ihead_ff <= ihead_in;
         free_ff <= free_in;
         run_ff <= run_in;
         run_idx_ff <= run_idx_in;
         run_vld_ff <= run_vld_in;
         rchg_ff <= rchg_in;
         utot_ff <= utot_in;
         fault_ff <= fault_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in;
      tix_ff <= tix_in; per_ff <= per_in; wcet_ff <= wcet_in;
      hard_ff <= hard_in; main_ff <= main_in;
      nxt_ff <= nxt_in;
      cur_ff <= cur_in; prv_ff <= prv_in;
      cur_idx_ff <= cur_idx_in; prv_idx_ff <= prv_idx_in; prv_vld_ff <= prv_vld_in;
      old_vld_ff <= old_vld_in; old_idx_ff <= old_idx_in;
      sel_ff <= sel_in; woke_ff <= woke_in;
      util_ff <= util_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
      st_ff <= st_in; created_ff <= created_in;
      rsp_st_ff <= rsp_st_in; rsp_run_ff <= rsp_run_in; rsp_cre_ff <= rsp_cre_in;
      rsp_sw_ff <= rsp_sw_in;
   end

endmodule
`default_nettype wire

/* tb/edf_task_scheduler_core_test.sv */
`timescale 1ns / 100ps
module edf_task_scheduler_core_test;

   localparam int N   = 16;
   localparam int NIL = 31;
   localparam int L_READY  = 0;
   localparam int L_IDLE   = 1;
   localparam int L_ZOMBIE = 2;
   localparam int L_FREE   = 3;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      logic [1:0]               op;
      logic [3:0]               idx;
      logic [edf_pkg::DL_W-1:0] per;
      logic [edf_pkg::DL_W-1:0] wcet;
      bit                       hard;
      bit                       is_main;
   } task_cmd_type;

   typedef struct {
      logic [edf_pkg::STATUS_W-1:0]  status;
      logic [edf_pkg::OUT_IDX_W-1:0] running;
      logic [edf_pkg::OUT_IDX_W-1:0] created;
      bit                            switched;
   } sched_rsp_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [edf_pkg::DL_W-1:0] csr_write_data;

   edf_req_if req ();
   edf_rsp_if rsp ();

   edf_task_scheduler_core #(.TASK_COUNT(N)) i_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req),
      .rsp_chan(rsp),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always #6 clock = ~clock;

   // scheduler shadow state
   logic [edf_pkg::DL_W-1:0]   sh_dl[N];
   logic [edf_pkg::DL_W-1:0]   sh_per[N];
   logic [edf_pkg::UTIL_W-1:0] sh_util[N];
   bit                         sh_hard[N];
   int                         sh_next[N];
   int                         sh_prev[N];
   logic [2:0]                 sh_phase[N];
   int                         sh_head[4];
   int                         sh_run;
   bit                         sh_run_ok;
   logic [edf_pkg::DL_W-1:0]   sh_clk;
   int                         sh_util_sum;
   bit                         sh_ready_dirty;
   logic [2:0]                 sh_fault;
   logic [edf_pkg::DL_W-1:0]   sh_lifetime;

   sched_rsp_type expected_rsp[$];
   int err_count = 0;
   int burst_left = 0;
   int cycles = 0;

   function automatic logic [edf_pkg::DL_W-1:0] dl_sum(logic [edf_pkg::DL_W-1:0] a,
                                                       logic [edf_pkg::DL_W-1:0] b);
      int s;
      s = int'(a) + int'(b);
      return (s > 32767) ? edf_pkg::DL_MAX : s[edf_pkg::DL_W-1:0];
   endfunction

   function automatic void shadow_reset();
      for (int i = 0; i < N; i++) begin
         sh_dl[i] = '0;
         sh_per[i] = '0;
         sh_util[i] = '0;
         sh_hard[i] = 0;
         sh_next[i] = (i + 1 < N) ? i + 1 : NIL;
         sh_prev[i] = NIL;
         sh_phase[i] = edf_pkg::PH_FREE;
      end
      sh_dl[0] = edf_pkg::DL_MAX;
      sh_phase[0] = edf_pkg::PH_EXEC;
      sh_head[L_READY] = NIL;
      sh_head[L_IDLE] = NIL;
      sh_head[L_ZOMBIE] = NIL;
      sh_head[L_FREE] = 1;
      sh_run = 0;
      sh_run_ok = 1;
      sh_clk = '0;
      sh_util_sum = 0;
      sh_ready_dirty = 0;
      sh_fault = edf_pkg::ST_OK;
      sh_lifetime = edf_pkg::DL_MAX;
   endfunction

   // sorted insert, equal deadlines go behind
   function automatic void list_put(int t, int l, logic [2:0] phase);
      int pv, nx, steps;
      pv = NIL;
      nx = sh_head[l];
      steps = 0;
      sh_phase[t] = phase;
      while (nx < N && steps < N && sh_dl[t] >= sh_dl[nx]) begin
         pv = nx;
         nx = sh_next[nx];
         steps++;
      end
      if (nx >= N) nx = NIL;
      if (pv != NIL) sh_next[pv] = t;
      else sh_head[l] = t;
      if (nx != NIL) sh_prev[nx] = t;
      sh_prev[t] = pv;
      sh_next[t] = nx;
   endfunction

   function automatic int list_take(int l);
      int h, n;
      h = sh_head[l];
      if (h >= N) begin
         sh_head[l] = NIL;
         return NIL;
      end
      n = sh_next[h];
      if (n >= N) n = NIL;
      sh_head[l] = n;
      if (n != NIL) sh_prev[n] = NIL;
      return h;
   endfunction

   function automatic void run_ready_head();
      int t;
      t = list_take(L_READY);
      if (t == NIL) begin
         sh_run_ok = 0;
         return;
      end
      sh_run = t;
      sh_run_ok = 1;
      sh_phase[t] = edf_pkg::PH_EXEC;
   endfunction

   function automatic void reschedule();
      sh_ready_dirty = 0;
      if (sh_head[L_READY] >= N) return;
      if (!sh_run_ok) begin
         run_ready_head();
         return;
      end
      if (sh_dl[sh_head[L_READY]] < sh_dl[sh_run]) begin
         list_put(sh_run, L_READY, edf_pkg::PH_READY);
         run_ready_head();
      end
   endfunction

   function automatic void clock_tick();
      int woke, t;
      woke = 0;
      sh_clk = sh_clk + 1'b1;
      if (sh_clk >= sh_lifetime) begin
         sh_fault = edf_pkg::ST_EXPIRED;
         return;
      end
      if (sh_run_ok && sh_hard[sh_run] && sh_clk > sh_dl[sh_run]) begin
         sh_fault = edf_pkg::ST_OVERRUN;
         return;
      end
      for (int g = 0; g < N && sh_head[L_ZOMBIE] < N &&
           sh_dl[sh_head[L_ZOMBIE]] <= sh_clk; g++) begin
         t = list_take(L_ZOMBIE);
         sh_util_sum = (sh_util_sum > int'(sh_util[t])) ? sh_util_sum - int'(sh_util[t]) : 0;
         list_put(t, L_FREE, edf_pkg::PH_FREE);
      end
      for (int g = 0; g < N && sh_head[L_IDLE] < N &&
           sh_dl[sh_head[L_IDLE]] <= sh_clk; g++) begin
         t = list_take(L_IDLE);
         sh_dl[t] = dl_sum(sh_dl[t], sh_per[t]);
         list_put(t, L_READY, edf_pkg::PH_READY);
         woke++;
      end
      if (woke > 0 || sh_ready_dirty) reschedule();
   endfunction

   function automatic void close_cycle();
      int r;
      if (sh_run_ok) begin
         r = sh_run;
         if (sh_clk < sh_dl[r]) begin
            list_put(r, L_IDLE, edf_pkg::PH_IDLE);
         end else begin
            sh_dl[r] = dl_sum(sh_dl[r], sh_per[r]);
            list_put(r, L_READY, edf_pkg::PH_READY);
         end
      end
      run_ready_head();
   endfunction

   function automatic sched_rsp_type predict_schedule(task_cmd_type c);
      sched_rsp_type e;
      bit old_ok;
      int old_run, t;
      longint u;
      old_ok = sh_run_ok;
      old_run = sh_run;
      e.status = edf_pkg::ST_OK;
      e.created = '0;
      if (sh_fault == edf_pkg::ST_OK) begin
         case (c.op)
            edf_pkg::OP_TICK: clock_tick();
            edf_pkg::OP_END: close_cycle();
            edf_pkg::OP_ACTIVATE: begin
               t = int'(c.idx);
               if (t < N && sh_phase[t] == edf_pkg::PH_SLEEP) begin
                  sh_ready_dirty = 1;
                  if (sh_hard[t]) sh_dl[t] = dl_sum(sh_clk, sh_per[t]);
                  list_put(t, L_READY, edf_pkg::PH_READY);
               end
            end
            default: begin
               if (c.per == 0) u = (c.wcet != 0) ? 65535 : 0;
               else begin
                  u = (longint'(c.wcet) << 16) / longint'(c.per);
                  if (u > 65535) u = 65535;
               end
               if (sh_head[L_FREE] >= N) begin
                  e.status = edf_pkg::ST_NO_FREE;
               end else if (c.hard && (c.wcet > c.per || sh_util_sum + u > 65536)) begin
                  e.status = edf_pkg::ST_NOT_GUAR;
               end else begin
                  t = list_take(L_FREE);
                  if (c.hard) sh_util_sum += int'(u);
                  sh_hard[t] = c.hard;
                  sh_phase[t] = edf_pkg::PH_SLEEP;
                  sh_per[t] = c.per;
                  sh_util[t] = u[15:0];
                  sh_dl[t] = c.is_main ? edf_pkg::DL_MAX : c.per;
                  e.created = t[3:0];
               end
            end
         endcase
      end
      if (sh_fault != edf_pkg::ST_OK) e.status = sh_fault;
      else if (e.status == edf_pkg::ST_OK && !sh_run_ok) e.status = edf_pkg::ST_NONE_READY;
      e.running = sh_run_ok ? sh_run[3:0] : 4'd0;
      e.switched = (sh_run_ok != old_ok) || (sh_run_ok && sh_run != old_run);
      return e;
   endfunction

   // response side
   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      err_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected beat, queue depth", 0, 0);
         end else begin
            sched_rsp_type w;
            w = expected_rsp.pop_front();
            if (rsp.status !== w.status)
               report_mismatch("status", int'(rsp.status), int'(w.status));
            if (rsp.running_task !== w.running)
               report_mismatch("running_task", int'(rsp.running_task), int'(w.running));
            if (rsp.created_task !== w.created)
               report_mismatch("created_task", int'(rsp.created_task), int'(w.created));
            if (rsp.switched !== w.switched)
               report_mismatch("switched", int'(rsp.switched), int'(w.switched));
         end
      end
   end

   // receiver stall pattern, set by a mode that is redrawn at random
   int stall_mode = 0;
   always @(posedge clock) begin
      if (cycles % 64 == 0) stall_mode <= int'($urandom_range(0, 3));
      case (stall_mode)
         0: rsp.ready <= 1'b1;
         1: rsp.ready <= ($urandom_range(0, 1) == 1);
         2: rsp.ready <= ($urandom_range(0, 3) == 0);
         default: rsp.ready <= (cycles % 8 < 5);
      endcase
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("edf_task_scheduler_core_test: errors");
         $finish;
      end
   end

   // sender side; every call starts and ends right after a rising edge
   task automatic send_beat(task_cmd_type c);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = int'($urandom_range(1, 12));
      end
      burst_left--;
      req.valid <= 1'b1;
      req.op <= c.op;
      req.task_slot <= c.idx;
      req.period_ticks <= c.per;
      req.wcet_ticks <= c.wcet;
      req.hard_task <= c.hard;
      req.main_type <= c.is_main;
      do @(posedge clock); while (!req.ready);
      expected_rsp.push_back(predict_schedule(c));
   endtask

   task automatic send_op(logic [1:0] op, logic [3:0] idx, int per = 0, int wcet = 0,
                          bit hard = 0, bit is_main = 0);
      task_cmd_type c;
      c.op = op;
      c.idx = idx;
      c.per = per[edf_pkg::DL_W-1:0];
      c.wcet = wcet[edf_pkg::DL_W-1:0];
      c.hard = hard;
      c.is_main = is_main;
      send_beat(c);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_lifetime(int v);
      csr_write_enable <= 1'b1;
      csr_write_data <= v[edf_pkg::DL_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sh_lifetime = v[edf_pkg::DL_W-1:0];
      @(posedge clock);
   endtask

   function automatic bit tick_would_fault();
      logic [edf_pkg::DL_W-1:0] nc;
      nc = sh_clk + 1'b1;
      return nc >= sh_lifetime || (sh_run_ok && sh_hard[sh_run] && nc > sh_dl[sh_run]);
   endfunction

   task automatic test_directed();
      send_op(edf_pkg::OP_ACTIVATE, 4'd15);                 // free entry, ignored
      send_op(edf_pkg::OP_CREATE, 4'd0, 10, 2, 1, 0);       // hard periodic
      send_op(edf_pkg::OP_CREATE, 4'd0, 5, 6, 1, 0);        // wcet above period
      send_op(edf_pkg::OP_CREATE, 4'd0, 0, 7, 0, 0);        // zero period, util saturates
      send_op(edf_pkg::OP_CREATE, 4'd0, 0, 0, 0, 1);        // zero period, zero wcet, main
      send_op(edf_pkg::OP_CREATE, 4'd0, 32767, 32767, 1, 0); // fails admission on total
      send_op(edf_pkg::OP_CREATE, 4'd15, 32767, 32767, 0, 1);
      send_op(edf_pkg::OP_CREATE, 4'd0, 32767, 0, 1, 0);    // hard, deadline will saturate
      send_op(edf_pkg::OP_ACTIVATE, 4'd1);
      send_op(edf_pkg::OP_ACTIVATE, 4'd1);                  // already ready
      send_op(edf_pkg::OP_TICK, 4'd0);                      // preempts main task
      send_op(edf_pkg::OP_END, 4'd0);
      send_op(edf_pkg::OP_END, 4'd0);                       // ready list empty
      send_op(edf_pkg::OP_TICK, 4'd0);                      // nothing running
      send_op(edf_pkg::OP_ACTIVATE, 4'd4);
      send_op(edf_pkg::OP_ACTIVATE, 4'd5);
      send_op(edf_pkg::OP_TICK, 4'd0);
      send_op(edf_pkg::OP_END, 4'd0);
      send_op(edf_pkg::OP_END, 4'd0);
      send_op(edf_pkg::OP_END, 4'd15);
   endtask

   task automatic test_random_mix(int n, bit guard);
      task_cmd_type c;
      int r;
      int sleepers[$];
      for (int k = 0; k < n; k++) begin
         c.idx = 4'($urandom_range(0, 15));
         c.per = 15'($urandom_range(0, 32767));
         c.wcet = 15'($urandom_range(0, 32767));
         c.hard = 1'($urandom_range(0, 1));
         c.is_main = 1'($urandom_range(0, 1));
         r = int'($urandom_range(0, 99));
         if (r < 38) c.op = edf_pkg::OP_TICK;
         else if (r < 68) c.op = edf_pkg::OP_END;
         else if (r < 84) c.op = edf_pkg::OP_ACTIVATE;
         else c.op = edf_pkg::OP_CREATE;
         if (guard && c.op == edf_pkg::OP_TICK && tick_would_fault()) c.op = edf_pkg::OP_END;
         if (c.op == edf_pkg::OP_ACTIVATE && $urandom_range(0, 4) != 0) begin
            sleepers = {};
            for (int i = 0; i < N; i++)
               if (sh_phase[i] == edf_pkg::PH_SLEEP) sleepers.push_back(i);
            if (sleepers.size() != 0)
               c.idx = 4'(sleepers[$urandom_range(0, sleepers.size() - 1)]);
         end
         if (c.op == edf_pkg::OP_CREATE) begin
            if ($urandom_range(0, 4) != 0) begin
               c.per = 15'($urandom_range(2, 60));
               c.wcet = 15'($urandom_range(0, int'(c.per) / 3));
               c.is_main = ($urandom_range(0, 9) == 0);
            end
            // a hard task with no period would stall the tick stream
            if (c.hard && c.per == 0) c.per = 15'd1;
         end
         send_beat(c);
      end
   endtask

   task automatic test_lifetime_phases();
      write_lifetime(int'(edf_pkg::DL_MAX));
      test_random_mix(140, 1);
      drain();
      write_lifetime(int'(sh_clk) + int'($urandom_range(600, 3000)));
      test_random_mix(140, 1);
      // sender holds until all outstanding beats have come back
      drain();
      write_lifetime(int'(sh_clk) + int'($urandom_range(400, 1000)));
      test_random_mix(140, 1);
      drain();
   endtask

   task automatic test_sticky_fault();
      write_lifetime(int'(sh_clk) + int'($urandom_range(2, 20)));
      test_random_mix(40, 0);
      drain();
      write_lifetime(1);
      test_random_mix(6, 0);
   endtask

   initial begin
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      req.valid <= 1'b0;
      req.op <= edf_pkg::OP_TICK;
      req.task_slot <= '0;
      req.period_ticks <= '0;
      req.wcet_ticks <= '0;
      req.hard_task <= 1'b0;
      req.main_type <= 1'b0;
      shadow_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain();
      test_lifetime_phases();
      test_sticky_fault();
      drain();
      if (err_count == 0 && expected_rsp.size() == 0) begin
         $display("edf_task_scheduler_core_test: clean");
      end else begin
         if (expected_rsp.size() != 0)
            report_mismatch("beats never returned", expected_rsp.size(), 0);
         $display("edf_task_scheduler_core_test: errors");
      end
      $finish;
   end
endmodule

/* sim.f */
design/edf_pkg.sv
design/edf_if.sv
design/edf_task_scheduler_core.sv
tb/edf_task_scheduler_core_test.sv
